// ----- rtl/prsat_pkg.sv -----
// Package: table constants, widths and segment types for the pressure to saturation temp unit
`timescale 1ns / 1ps

package prsat_pkg;

  // Table size and field widths
  localparam int TABLE_POINTS = 20;
  localparam int SEG_W        = $clog2(TABLE_POINTS);
  localparam int P_W          = 14;
  localparam int T_W          = 12;
  localparam int BASE_W       = 28;
  localparam int SLOPE_W      = 15;
  localparam int D_W          = 9;
  localparam int PROD_W       = D_W + SLOPE_W;
  localparam int ACC_W        = BASE_W + 1;
  localparam int FRAC_SH      = 16;
  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);

  // Breakpoint pressures in 1/16 psig
  localparam logic [P_W-1:0] BP_X16 [0:TABLE_POINTS-1] = '{
    14'd1824, 14'd2240, 14'd2560, 14'd2880, 14'd3200,
    14'd3456, 14'd3840, 14'd4160, 14'd4480, 14'd4800,
    14'd5088, 14'd5440, 14'd5760, 14'd6080, 14'd6400,
    14'd6720, 14'd7040, 14'd7360, 14'd7680, 14'd8000
  };

  // Segment base in Q16 temp_x16 units, indexed by upper breakpoint (entry 0 unused)
  localparam logic [BASE_W-1:0] SEG_BASE [0:TABLE_POINTS-1] = '{
    28'd0,
    28'd39636173, 28'd49283072, 28'd56623104, 28'd63963136, 28'd71303168,
    28'd77909197, 28'd85983232, 28'd92274688, 28'd98041856, 28'd102236160,
    28'd105067315, 28'd109051904, 28'd113246208, 28'd117440512, 28'd121634816,
    28'd126563123, 28'd130023424, 28'd133169152, 28'd136314880
  };

  // Segment slope in Q16 temp_x16 units per 1/16 psig (entry 0 unused)
  localparam logic [SLOPE_W-1:0] SEG_SLOPE [0:TABLE_POINTS-1] = '{
    15'd0,
    15'd23190, 15'd22938, 15'd22938, 15'd22938, 15'd25805,
    15'd21026, 15'd19661, 15'd18022, 15'd13107, 15'd9830,
    15'd11320, 15'd13107, 15'd13107, 15'd13107, 15'd15401,
    15'd10813, 15'd9830, 15'd9830, 15'd13107
  };

  // Segment terms handed from the select stage to the interpolator
  typedef struct packed {
    logic               oor;
    logic [BASE_W-1:0]  base;
    logic [SLOPE_W-1:0] slope;
    logic [D_W-1:0]     d;
  } seg_t;

endpackage

// ----- rtl/prsat_in_if.sv -----
// Interface: pressure input channel
`timescale 1ns / 1ps

interface prsat_in_if;
  logic                       valid;
  logic                       ready;
  logic [prsat_pkg::P_W-1:0]  pressure_x16;

  modport source (output valid, output pressure_x16, input ready);
  modport sink   (input valid, input pressure_x16, output ready);
endinterface

// ----- rtl/prsat_out_if.sv -----
// Interface: saturation temperature result channel
`timescale 1ns / 1ps

interface prsat_out_if;
  logic                       valid;
  logic                       ready;
  logic [prsat_pkg::T_W-1:0]  temp_x16;
  logic                       out_of_range;

  modport source (output valid, output temp_x16, output out_of_range, input ready);
  modport sink   (input valid, input temp_x16, input out_of_range, output ready);
endinterface

// ----- rtl/refrigerant_pressure_to_sat_temp_unit.sv -----
// Top level: gauge pressure to saturation temperature by piecewise linear lookup
// Datapath: the accepted input beat passes the input register, the segment
//   register and the result register, in that order.
// Throughput: one beat per cycle while the result side holds ready high; a full
//   stage holds its beat only when the stage after it cannot take one.
// Reset: synchronous active-low rst_n clears all stage valid flags; no other state.
`timescale 1ns / 1ps

module refrigerant_pressure_to_sat_temp_unit (
  input  logic          clk,
  input  logic          rst_n,
  prsat_in_if.sink      in_ch,
  prsat_out_if.source   out_ch
);

  prsat_pkg::seg_t  seg;
  logic             seg_valid;
  logic             seg_ready;

  // Segment select stage
  prsat_seg_sel u_seg_sel (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .seg_o       (seg),
    .seg_valid_o (seg_valid),
    .seg_ready_i (seg_ready)
  );

  // Interpolation stage
  prsat_interp u_interp (
    .clk         (clk),
    .rst_n       (rst_n),
    .seg_i       (seg),
    .seg_valid_i (seg_valid),
    .seg_ready_o (seg_ready),
    .out_ch      (out_ch)
  );

endmodule

// ----- rtl/prsat_seg_sel.sv -----
// Input register, range check and segment select with offset computation
`timescale 1ns / 1ps

module prsat_seg_sel (
  input  logic              clk,
  input  logic              rst_n,
  prsat_in_if.sink          in_ch,
  output prsat_pkg::seg_t   seg_o,
  output logic              seg_valid_o,
  input  logic              seg_ready_i
);

  logic                             in_valid_r;
  logic [prsat_pkg::P_W-1:0]        in_p_r;
  logic                             seg_valid_r;
  prsat_pkg::seg_t                  seg_r;
  prsat_pkg::seg_t                  seg_nxt;
  logic                             seg_adv;
  logic                             in_adv;
  logic [prsat_pkg::SEG_W-1:0]      seg_idx;
  logic [prsat_pkg::SEG_W-1:0]      lo_idx;
  logic [prsat_pkg::P_W-1:0]        diff;

  // Ready chain: a stage moves when it is empty or the next one moves
  assign seg_adv     = !seg_valid_r || seg_ready_i;
  assign in_adv      = !in_valid_r || seg_adv;
  assign in_ch.ready = in_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_adv) begin
      in_valid_r <= in_ch.valid;
    end
    if (in_adv && in_ch.valid) begin
      in_p_r <= in_ch.pressure_x16;
    end
  end

  // First breakpoint at or above the pressure; last segment by default
  always_comb begin
    seg_idx = prsat_pkg::SEG_W'(prsat_pkg::TABLE_POINTS - 1);
    for (int k = prsat_pkg::TABLE_POINTS - 1; k >= 1; k--) begin
      if (in_p_r <= prsat_pkg::BP_X16[k]) begin
        seg_idx = prsat_pkg::SEG_W'(k);
      end
    end
  end

  // Offset into the segment and its constants
  always_comb begin
    lo_idx        = seg_idx - 1'b1;
    diff          = in_p_r - prsat_pkg::BP_X16[lo_idx];
    seg_nxt.oor   = (in_p_r < prsat_pkg::BP_X16[0]) ||
                    (in_p_r > prsat_pkg::BP_X16[prsat_pkg::TABLE_POINTS-1]);
    seg_nxt.base  = prsat_pkg::SEG_BASE[seg_idx];
    seg_nxt.slope = prsat_pkg::SEG_SLOPE[seg_idx];
    seg_nxt.d     = diff[prsat_pkg::D_W-1:0];
  end

  // Segment register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_valid_r <= 1'b0;
    end else if (seg_adv) begin
      seg_valid_r <= in_valid_r;
    end
    if (seg_adv && in_valid_r) begin
      seg_r <= seg_nxt;
    end
  end

  assign seg_o       = seg_r;
  assign seg_valid_o = seg_valid_r;

endmodule

// ----- rtl/prsat_interp.sv -----
// Multiply-add interpolation, rounding and result register
`timescale 1ns / 1ps

module prsat_interp (
  input  logic              clk,
  input  logic              rst_n,
  input  prsat_pkg::seg_t   seg_i,
  input  logic              seg_valid_i,
  output logic              seg_ready_o,
  prsat_out_if.source       out_ch
);

  localparam logic [prsat_pkg::T_W-1:0] TEMP_MIN = prsat_pkg::T_W'(605);
  localparam logic [prsat_pkg::T_W-1:0] TEMP_MAX = prsat_pkg::T_W'(2144);
  localparam logic [prsat_pkg::D_W-1:0] D_MAX    = prsat_pkg::D_W'(416);

  logic                              out_valid_r;
  logic [prsat_pkg::T_W-1:0]         temp_r;
  logic [prsat_pkg::T_W-1:0]         temp_nxt;
  logic                              oor_r;
  logic                              out_adv;
  logic [prsat_pkg::PROD_W-1:0]      prod;
  logic [prsat_pkg::ACC_W-1:0]       acc;

  assign out_adv     = !out_valid_r || out_ch.ready;
  assign seg_ready_o = out_adv;

  // base + d * slope, rounded to nearest 1/16; zero when out of range
  always_comb begin
    prod     = prsat_pkg::PROD_W'(seg_i.d) * prsat_pkg::PROD_W'(seg_i.slope);
    acc      = prsat_pkg::ACC_W'(seg_i.base) + prsat_pkg::ACC_W'(prod) + prsat_pkg::ROUND_HALF;
    temp_nxt = seg_i.oor ? '0 : acc[prsat_pkg::FRAC_SH +: prsat_pkg::T_W];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= seg_valid_i;
    end
    if (out_adv && seg_valid_i) begin
      temp_r <= temp_nxt;
      oor_r  <= seg_i.oor;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.temp_x16     = temp_r;
  assign out_ch.out_of_range = oor_r;

  // Out-of-range beats carry a zero temperature
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && oor_r |-> temp_r == '0)
    else $error("out of range beat with nonzero temperature");

  // In-range beats stay inside the table's temperature span
  a_temp_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !oor_r |-> (temp_r >= TEMP_MIN) && (temp_r <= TEMP_MAX))
    else $error("in range temperature outside table span");

  // Segment offset never exceeds the widest segment
  a_d_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seg_valid_i && !seg_i.oor |-> seg_i.d <= D_MAX)
    else $error("segment offset too large");

  // Reset empties the result register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid right after reset");

endmodule
